/* rtl/aspd_pkg.sv */
package aspd_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ImmW   = 16;
  localparam int unsigned NumLanes = 4;

  localparam logic [3:0]  CondAl      = 4'hE;
  localparam logic [3:0]  RegR12      = 4'hC;
  localparam logic [20:0] BxPattern   = 21'h12FFF1;
  localparam logic [20:0] BlxPattern  = 21'h12FFF3;
  localparam logic [11:0] Imm12Mask   = 12'hFFF;
  localparam logic [6:0]  AdrRnPc     = 7'h4F;

  typedef enum logic [2:0] {
    CLS_UNKNOWN = 3'd0,
    CLS_SVC     = 3'd1,
    CLS_MOVW    = 3'd2,
    CLS_MOVT    = 3'd3,
    CLS_ADR     = 3'd4,
    CLS_MVN     = 3'd5,
    CLS_BRANCH  = 3'd6
  } cls_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_SYSCALL = 2'd1,
    KIND_FUNC    = 2'd2
  } kind_t;

  typedef struct packed {
    cls_t            cls;
    logic [ImmW-1:0] imm;
  } lane_res_t;

  typedef struct packed {
    kind_t            kind;
    logic [WordW-1:0] value;
  } stub_res_t;

endpackage

/* rtl/aspd_lane.sv */
module aspd_lane (
  input  logic [aspd_pkg::WordW-1:0] word,
  output aspd_pkg::lane_res_t        res
);

  logic cond_al;
  logic rd_r12;

  assign cond_al = (word[31:28] == aspd_pkg::CondAl);
  assign rd_r12  = (word[15:12] == aspd_pkg::RegR12);

  always_comb begin
    res.cls = aspd_pkg::CLS_UNKNOWN;
    res.imm = '0;
    if (cond_al) begin
      if (word[27]) begin
        if (word[26:24] == 3'b111) begin
          res.cls = aspd_pkg::CLS_SVC;
        end
      end else if (!word[26] && word[25]) begin
        case (word[24:23])
          2'b10: begin
            if (!word[21] && !word[20] && rd_r12) begin
              res.imm = {word[19:16], word[11:0] & aspd_pkg::Imm12Mask};
              res.cls = word[22] ? aspd_pkg::CLS_MOVT : aspd_pkg::CLS_MOVW;
            end
          end
          2'b00: begin
            if (word[22:16] == aspd_pkg::AdrRnPc && rd_r12) begin
              res.cls = aspd_pkg::CLS_ADR;
            end
          end
          2'b11: begin
            if (word[22] && word[21]) begin
              res.cls = aspd_pkg::CLS_MVN;
            end
          end
          default: res.cls = aspd_pkg::CLS_UNKNOWN;
        endcase
      end else if (!word[26] && !word[25]) begin
        if (word[24:4] == aspd_pkg::BxPattern || word[24:4] == aspd_pkg::BlxPattern) begin
          res.cls = aspd_pkg::CLS_BRANCH;
        end
      end
    end
  end

endmodule

/* rtl/aspd_merge.sv */
module aspd_merge (
  input  aspd_pkg::lane_res_t lanes [aspd_pkg::NumLanes],
  output aspd_pkg::stub_res_t res
);

  logic frame_ok;

  assign frame_ok = (lanes[0].cls == aspd_pkg::CLS_MOVW)
                 && (lanes[2].cls == aspd_pkg::CLS_BRANCH)
                 && (lanes[3].cls == aspd_pkg::CLS_UNKNOWN);

  always_comb begin
    res.kind  = aspd_pkg::KIND_NONE;
    res.value = '0;
    if (frame_ok) begin
      if (lanes[1].cls == aspd_pkg::CLS_SVC) begin
        res.kind  = aspd_pkg::KIND_SYSCALL;
        res.value = {{(aspd_pkg::WordW-aspd_pkg::ImmW){1'b0}}, lanes[0].imm};
      end else if (lanes[1].cls == aspd_pkg::CLS_MOVT) begin
        res.kind  = aspd_pkg::KIND_FUNC;
        res.value = {lanes[1].imm, lanes[0].imm};
      end
    end
  end

endmodule

/* rtl/arm_stub_pattern_decoder_unit.sv */
// ARM call-stub decoder. Each input transaction carries four stub words; four
// classifier lanes sort them in parallel and a merge stage reports a syscall
// stub (MOVW, SVC, BX/BLX, other) with its 16-bit number or a function stub
// (MOVW, MOVT, BX/BLX, other) with its 32-bit address. One stub is taken per
// cycle while in_tready is high; its result is registered. A two-entry output
// buffer (result register plus skid register) keeps in_tready high for one
// extra transaction while the result side stalls.
module arm_stub_pattern_decoder_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // word0, word1, word2, word3
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata   // stub_kind[1:0], stub_value[33:2], zero pad
);

  aspd_pkg::lane_res_t lanes [aspd_pkg::NumLanes];
  aspd_pkg::stub_res_t merged;

  for (genvar g = 0; g < aspd_pkg::NumLanes; g++) begin : g_lane
    aspd_lane u_lane (
      .word (in_tdata[g*aspd_pkg::WordW +: aspd_pkg::WordW]),
      .res  (lanes[g])
    );
  end

  aspd_merge u_merge (
    .lanes (lanes),
    .res   (merged)
  );

  aspd_pkg::stub_res_t main_r, main_nxt, skid_r, skid_nxt;
  logic                main_vld_r, main_vld_nxt, skid_vld_r, skid_vld_nxt;
  logic                accept, pop;

  assign in_tready = !skid_vld_r;
  assign accept    = in_tvalid && in_tready;
  assign pop       = main_vld_r && out_tready;

  always_comb begin
    main_nxt     = main_r;
    main_vld_nxt = main_vld_r;
    skid_nxt     = skid_r;
    skid_vld_nxt = skid_vld_r;
    if (pop || !main_vld_r) begin
      if (skid_vld_r) begin
        main_nxt     = skid_r;
        main_vld_nxt = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        main_nxt     = merged;
        main_vld_nxt = accept;
      end
    end else if (accept) begin
      skid_nxt     = merged;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = main_vld_r;
  assign out_tdata  = {6'b0, main_r.value, main_r.kind};

endmodule

/* rtl/aspd_checker.sv */
module aspd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [39:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'b11)
    else $error("illegal stub kind");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == 2'b00 |-> out_tdata[33:2] == 32'd0)
    else $error("nonzero value without match");

  a_svc_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == 2'b01 |-> out_tdata[33:18] == 16'd0)
    else $error("syscall number wider than 16 bits");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("empty buffer not ready");

endmodule

bind arm_stub_pattern_decoder_unit aspd_checker u_aspd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* bench/stub_decode_checker.sv */
module stub_decode_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [39:0]  out_tdata,
  output int           fail_count,
  output int           awaited
);

  aspd_pkg::stub_res_t pending_stubs[$];
  int                  errs;

  function automatic aspd_pkg::cls_t sort_word(input logic [31:0] w,
                                               output logic [15:0] imm);
    imm = '0;
    if (w[31:28] != aspd_pkg::CondAl) return aspd_pkg::CLS_UNKNOWN;
    if (w[27]) return (w[26:24] == 3'b111) ? aspd_pkg::CLS_SVC : aspd_pkg::CLS_UNKNOWN;
    if (!w[26] && w[25]) begin
      if (w[24] && !w[23]) begin
        if (w[21] || w[20] || w[15:12] != aspd_pkg::RegR12) return aspd_pkg::CLS_UNKNOWN;
        imm = {w[19:16], w[11:0]};
        return w[22] ? aspd_pkg::CLS_MOVT : aspd_pkg::CLS_MOVW;
      end
      if (!w[24] && !w[23])
        return (w[22:16] == aspd_pkg::AdrRnPc && w[15:12] == aspd_pkg::RegR12) ?
               aspd_pkg::CLS_ADR : aspd_pkg::CLS_UNKNOWN;
      if (w[24] && w[23])
        return (w[22] && w[21]) ? aspd_pkg::CLS_MVN : aspd_pkg::CLS_UNKNOWN;
      return aspd_pkg::CLS_UNKNOWN;
    end
    if (!w[26] && !w[25] &&
        (w[24:4] == aspd_pkg::BxPattern || w[24:4] == aspd_pkg::BlxPattern))
      return aspd_pkg::CLS_BRANCH;
    return aspd_pkg::CLS_UNKNOWN;
  endfunction

  function automatic aspd_pkg::stub_res_t predict_stub(input logic [127:0] d);
    aspd_pkg::cls_t      lane_cls[4];
    logic [15:0]         lane_imm[4];
    aspd_pkg::stub_res_t r;
    for (int i = 0; i < 4; i++) lane_cls[i] = sort_word(d[32*i +: 32], lane_imm[i]);
    r.kind  = aspd_pkg::KIND_NONE;
    r.value = '0;
    if (lane_cls[0] == aspd_pkg::CLS_MOVW && lane_cls[2] == aspd_pkg::CLS_BRANCH &&
        lane_cls[3] == aspd_pkg::CLS_UNKNOWN) begin
      if (lane_cls[1] == aspd_pkg::CLS_SVC) begin
        r.kind  = aspd_pkg::KIND_SYSCALL;
        r.value = {16'h0, lane_imm[0]};
      end else if (lane_cls[1] == aspd_pkg::CLS_MOVT) begin
        r.kind  = aspd_pkg::KIND_FUNC;
        r.value = {lane_imm[1], lane_imm[0]};
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    aspd_pkg::stub_res_t exp_res;
    logic [1:0]          got_kind;
    logic [31:0]         got_value;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_kind  = out_tdata[1:0];
        got_value = out_tdata[33:2];
        if (pending_stubs.size() == 0) begin
          errs++;
          $error("result transaction with no stub pending: kind %0d value 0x%08h",
                 got_kind, got_value);
        end else begin
          exp_res = pending_stubs.pop_front();
          if (got_kind !== exp_res.kind) begin
            errs++;
            $error("stub_kind mismatch: expected %0d, actual %0d", exp_res.kind, got_kind);
          end
          if (got_value !== exp_res.value) begin
            errs++;
            $error("stub_value mismatch: expected 0x%08h, actual 0x%08h",
                   exp_res.value, got_value);
          end
        end
      end
      if (in_tvalid && in_tready) pending_stubs.push_back(predict_stub(in_tdata));
    end
    fail_count <= errs;
    awaited    <= pending_stubs.size();
  end

endmodule

/* bench/tb_arm_stub_pattern_decoder_unit.sv */
module tb_arm_stub_pattern_decoder_unit;

  localparam int CycleLimit = 200000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [39:0]  out_tdata;

  int fail_count;
  int awaited;
  int send_idle = 8;
  int recv_idle = 65;
  int cycles = 0;

  arm_stub_pattern_decoder_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  stub_decode_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .awaited    (awaited)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle);

  function automatic logic [31:0] mk_mov(input logic movt, input logic [15:0] imm);
    return {aspd_pkg::CondAl, 5'b00110, movt, 2'b00, imm[15:12], aspd_pkg::RegR12,
            imm[11:0]};
  endfunction

  function automatic logic [31:0] mk_svc(input logic [23:0] num);
    return {aspd_pkg::CondAl, 4'hF, num};
  endfunction

  function automatic logic [31:0] mk_branch(input logic blx, input logic [3:0] rm);
    return {aspd_pkg::CondAl, 3'b000, blx ? aspd_pkg::BlxPattern : aspd_pkg::BxPattern, rm};
  endfunction

  function automatic logic [31:0] with_cond(input logic [31:0] w, input logic [3:0] cond);
    return {cond, w[27:0]};
  endfunction

  function automatic logic [31:0] rand_of_class(input aspd_pkg::cls_t c);
    logic [31:0] r;
    r = $urandom();
    case (c)
      aspd_pkg::CLS_SVC:    return mk_svc(r[23:0]);
      aspd_pkg::CLS_MOVW:   return mk_mov(1'b0, r[15:0]);
      aspd_pkg::CLS_MOVT:   return mk_mov(1'b1, r[15:0]);
      aspd_pkg::CLS_ADR:    return {aspd_pkg::CondAl, 8'h24, 4'hF, aspd_pkg::RegR12, r[11:0]};
      aspd_pkg::CLS_MVN:    return {aspd_pkg::CondAl, 7'h1F, r[20:0]};
      aspd_pkg::CLS_BRANCH: return mk_branch(r[31], r[3:0]);
      default:              return r;
    endcase
  endfunction

  // mostly raw noise, sometimes a real encoding under a non-AL condition
  function automatic logic [31:0] odd_word();
    int cond;
    cond = $urandom_range(14);
    if (cond == 14) cond = 15;
    if ($urandom_range(3) == 0)
      return with_cond(rand_of_class(aspd_pkg::cls_t'($urandom_range(1, 6))), cond[3:0]);
    return $urandom();
  endfunction

  task automatic send_stub(input logic [31:0] w0, input logic [31:0] w1,
                           input logic [31:0] w2, input logic [31:0] w3);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {w3, w2, w1, w0};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random_stub();
    logic [31:0] w[4];
    int          pick;
    int          lane;
    pick = $urandom_range(99);
    if (pick < 80) begin
      w[0] = mk_mov(1'b0, 16'($urandom()));
      w[1] = (pick < 40) ? mk_svc(24'($urandom())) : mk_mov(1'b1, 16'($urandom()));
      w[2] = mk_branch(1'($urandom_range(1)), 4'($urandom()));
      w[3] = odd_word();
      if ($urandom_range(99) < 15) begin
        lane = $urandom_range(3);
        if ($urandom_range(1)) w[lane] ^= 32'h1 << $urandom_range(31);
        else w[lane] = rand_of_class(aspd_pkg::cls_t'($urandom_range(6)));
      end
    end else begin
      for (int i = 0; i < 4; i++)
        w[i] = $urandom_range(1) ? rand_of_class(aspd_pkg::cls_t'($urandom_range(6)))
                                 : $urandom();
    end
    send_stub(w[0], w[1], w[2], w[3]);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero immediates still report the kind
    send_stub(mk_mov(1'b0, 16'h0), mk_svc(24'h0), mk_branch(1'b0, 4'h0), 32'h0);
    send_stub(mk_mov(1'b0, 16'hFFFF), mk_svc(24'hFFFFFF), mk_branch(1'b1, 4'hF), '1);
    send_stub(mk_mov(1'b0, 16'h0), mk_mov(1'b1, 16'h0), mk_branch(1'b0, 4'h0), 32'h0);
    send_stub(mk_mov(1'b0, 16'hFFFF), mk_mov(1'b1, 16'hFFFF), mk_branch(1'b1, 4'hF), '1);
    send_stub(mk_mov(1'b0, 16'h1234), mk_mov(1'b1, 16'h8001), mk_branch(1'b0, 4'h5),
              32'hE000_0000);
    send_stub(32'h0, 32'h0, 32'h0, 32'h0);
    send_stub('1, '1, '1, '1);
    // fourth word of every known class breaks the pattern
    for (int c = 1; c <= 6; c++)
      send_stub(mk_mov(1'b0, 16'($urandom())), mk_svc(24'($urandom())),
                mk_branch(1'b0, 4'h3), rand_of_class(aspd_pkg::cls_t'(c)));
    // second word of the other classes
    for (int c = 0; c <= 6; c++)
      if (aspd_pkg::cls_t'(c) != aspd_pkg::CLS_SVC &&
          aspd_pkg::cls_t'(c) != aspd_pkg::CLS_MOVT)
        send_stub(mk_mov(1'b0, 16'($urandom())), rand_of_class(aspd_pkg::cls_t'(c)),
                  mk_branch(1'b1, 4'h0), 32'h0);
    send_stub(mk_mov(1'b1, 16'h4321), mk_svc(24'h1), mk_branch(1'b0, 4'h1), 32'h0);
    send_stub(mk_mov(1'b0, 16'h4321), mk_svc(24'h1), mk_mov(1'b0, 16'h1), 32'h0);
    send_stub(with_cond(mk_mov(1'b0, 16'h5), 4'hD), mk_svc(24'h2), mk_branch(1'b0, 4'h2), 32'h0);
    send_stub(mk_mov(1'b0, 16'h5), with_cond(mk_svc(24'h2), 4'hF), mk_branch(1'b0, 4'h2), 32'h0);
    send_stub(mk_mov(1'b0, 16'h7) ^ 32'h0000_1000, mk_svc(24'h3), mk_branch(1'b0, 4'h0), 32'h0);
    send_stub(mk_mov(1'b0, 16'h7) | 32'h0010_0000, mk_mov(1'b1, 16'h9),
              mk_branch(1'b1, 4'h0), 32'h0);
    send_stub(mk_mov(1'b0, 16'h7), mk_svc(24'h3), mk_branch(1'b0, 4'h0) ^ 32'h10, 32'h0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 8 : (ph == 1) ? 65 : 0;
      recv_idle = (ph == 0) ? 65 : (ph == 1) ? 8 : 0;
      repeat (284) send_random_stub();
    end
    in_tvalid <= 1'b0;
    recv_idle = 0;

    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (awaited != 0) $error("%0d stubs left without a result", awaited);
    if (fail_count == 0 && awaited == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/aspd_pkg.sv
rtl/aspd_lane.sv
rtl/aspd_merge.sv
rtl/arm_stub_pattern_decoder_unit.sv
rtl/aspd_checker.sv
bench/stub_decode_checker.sv
bench/tb_arm_stub_pattern_decoder_unit.sv
